### rtl/bir_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bilinear image resize package
// Field widths, register indexes, opcodes and the sequencer states shared by
// the resize block.
// ----------------------------------------------------------------------------
package bir_pkg;

  localparam int POS_BITS       = 12;
  localparam int CHAN_FIELD_BITS = 16;
  localparam int SIZE_BITS      = 9;
  localparam int STEP_BITS      = 24;
  localparam int PROD_BITS      = POS_BITS + STEP_BITS;
  localparam int IN_TDATA_BITS  = 2 * POS_BITS + 4 * CHAN_FIELD_BITS;
  localparam int OUT_TDATA_BITS = 4 * CHAN_FIELD_BITS;
  localparam int CFG_ADDR_BITS  = 2;
  localparam int CFG_DATA_BITS  = STEP_BITS;

  typedef logic [CFG_ADDR_BITS-1:0] cfg_addr_t;

  localparam cfg_addr_t CFG_SRC_WIDTH  = 2'd0;
  localparam cfg_addr_t CFG_SRC_HEIGHT = 2'd1;
  localparam cfg_addr_t CFG_X_STEP     = 2'd2;
  localparam cfg_addr_t CFG_Y_STEP     = 2'd3;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [SIZE_BITS-1:0] SRC_SIZE_RESET = 9'd256;
  localparam logic [STEP_BITS-1:0] STEP_RESET     = 24'd65536;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CLAMP,
    ST_LERPX,
    ST_LERPY
  } state_t;

endpackage

`default_nettype wire

### rtl/bilinear_image_resize_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bilinear image resize top level
// Stores a source RGBA frame in four row/column parity banks and returns
// bilinear samples of it at scaled destination positions.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake             Word
//  in_       slave      in_tvalid/in_tready   tuser opcode, tdata pos and pixel
//  out_      master     out_tvalid/out_tready tdata four blended channels
//  cfg_      write      cfg_we                index cfg_addr, data cfg_wdata
//
// A write word goes straight into its bank.
// A read word passes through the sequencer: position multiply,
// clamp and bank read, horizontal blend, vertical blend into the output register.
// The output register frees the input side: the next word is taken while a
// result waits; a finished read holds in the last stage until that register is free.
// Reset is synchronous and clears control state and the configuration registers;
// the pixel store is not cleared and reads of unwritten pixels are undefined.
// ----------------------------------------------------------------------------
module bilinear_image_resize_top
  import bir_pkg::*;
#(
  parameter int MAX_WIDTH    = 256,
  parameter int MAX_HEIGHT   = 256,
  parameter int CHANNEL_BITS = 16,
  parameter int FRAC_BITS    = 16
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_tvalid,
  output logic                      in_tready,
  // pos_x, pos_y, red_in, green_in, blue_in, alpha_in
  input  wire [IN_TDATA_BITS-1:0]   in_tdata,
  // opcode
  input  wire                       in_tuser,
  output logic                      out_tvalid,
  input  wire                       out_tready,
  // red_out, green_out, blue_out, alpha_out
  output logic [OUT_TDATA_BITS-1:0] out_tdata,
  input  wire                       cfg_we,
  input  wire [CFG_ADDR_BITS-1:0]   cfg_addr,
  input  wire [CFG_DATA_BITS-1:0]   cfg_wdata
);

  localparam int XW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW         = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int XAW        = (XW > 1) ? XW - 1 : 1;
  localparam int YAW        = (YW > 1) ? YW - 1 : 1;
  localparam int BANK_DEPTH = 2 ** (XAW + YAW);
  localparam int CB         = CHANNEL_BITS;
  localparam int PW         = 4 * CB;
  localparam int IXW        = PROD_BITS - FRAC_BITS;

  // Signed blend: l + floor((r - l) * f / 2^FRAC_BITS).
  function automatic logic [CB-1:0] lerp(input logic [CB-1:0] l,
                                         input logic [CB-1:0] r,
                                         input logic [FRAC_BITS-1:0] f);
    logic signed [CB:0]              d;
    logic signed [CB+FRAC_BITS+1:0]  p;
    logic signed [CB+1:0]            s;
    d = $signed({1'b0, r}) - $signed({1'b0, l});
    p = d * $signed({1'b0, f});
    s = $signed({2'b00, l}) + (CB+2)'(p >>> FRAC_BITS);
    return s[CB-1:0];
  endfunction

  // Configuration registers.
  logic [SIZE_BITS-1:0] src_width_r, src_height_r;
  logic [STEP_BITS-1:0] x_step_r, y_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= SRC_SIZE_RESET;
      src_height_r <= SRC_SIZE_RESET;
      x_step_r     <= STEP_RESET;
      y_step_r     <= STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_SRC_WIDTH:  src_width_r  <= cfg_wdata[SIZE_BITS-1:0];
        CFG_SRC_HEIGHT: src_height_r <= cfg_wdata[SIZE_BITS-1:0];
        CFG_X_STEP:     x_step_r     <= cfg_wdata;
        CFG_Y_STEP:     y_step_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input word fields.
  logic [POS_BITS-1:0] in_pos_x, in_pos_y;
  logic [PW-1:0]       in_pix;
  logic                in_acc;

  assign in_pos_x = in_tdata[POS_BITS-1:0];
  assign in_pos_y = in_tdata[2*POS_BITS-1:POS_BITS];
  assign in_pix = {in_tdata[2*POS_BITS+3*CHAN_FIELD_BITS +: CB],
                   in_tdata[2*POS_BITS+2*CHAN_FIELD_BITS +: CB],
                   in_tdata[2*POS_BITS+CHAN_FIELD_BITS +: CB],
                   in_tdata[2*POS_BITS +: CB]};
  assign in_acc = in_tvalid && in_tready;

  // Sequencer.
  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   load_out;

  assign in_tready = (state_r == ST_IDLE);
  assign load_out  = (state_r == ST_LERPY) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_tuser == OP_READ) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:   state_nxt = ST_CLAMP;
      ST_CLAMP: state_nxt = ST_LERPX;
      ST_LERPX: state_nxt = ST_LERPY;
      ST_LERPY: begin
        if (load_out) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Destination position, then source position and fraction.
  logic [POS_BITS-1:0]  px_r, py_r;
  logic [PROD_BITS-1:0] sx, sy;
  logic [IXW-1:0]       ix_r, iy_r;
  logic [FRAC_BITS-1:0] fx_r, fy_r;

  assign sx = {{STEP_BITS{1'b0}}, px_r} * {{POS_BITS{1'b0}}, x_step_r};
  assign sy = {{STEP_BITS{1'b0}}, py_r} * {{POS_BITS{1'b0}}, y_step_r};

  always_ff @(posedge clk) begin
    if (in_acc) begin
      px_r <= in_pos_x;
      py_r <= in_pos_y;
    end
    if (state_r == ST_MUL) begin
      ix_r <= sx[PROD_BITS-1:FRAC_BITS];
      iy_r <= sy[PROD_BITS-1:FRAC_BITS];
      fx_r <= sx[FRAC_BITS-1:0];
      fy_r <= sy[FRAC_BITS-1:0];
    end
  end

  // Last column and row in use.
  logic [XW-1:0] last_x, left, right;
  logic [YW-1:0] last_y, top, bot;

  always_comb begin
    if (src_width_r == '0) begin
      last_x = '0;
    end else if ({4'b0, src_width_r} > 13'(MAX_WIDTH)) begin
      last_x = XW'(MAX_WIDTH - 1);
    end else begin
      last_x = XW'(src_width_r - 9'd1);
    end
    if (src_height_r == '0) begin
      last_y = '0;
    end else if ({4'b0, src_height_r} > 13'(MAX_HEIGHT)) begin
      last_y = YW'(MAX_HEIGHT - 1);
    end else begin
      last_y = YW'(src_height_r - 9'd1);
    end
  end

  // The neighbor one further is clamped when the base is at or past the edge.
  always_comb begin
    left  = (ix_r > IXW'(last_x)) ? last_x : XW'(ix_r);
    right = (ix_r >= IXW'(last_x)) ? last_x : XW'(ix_r + 1'b1);
    top   = (iy_r > IXW'(last_y)) ? last_y : YW'(iy_r);
    bot   = (iy_r >= IXW'(last_y)) ? last_y : YW'(iy_r + 1'b1);
  end

  // Parity banks: bank index is {row parity, column parity}. Unless clamped
  // together, the two columns (rows) have opposite parity, so each bank holds
  // exactly one of the four neighbors.
  logic                  wr_en;
  logic [1:0]            wr_bank;
  logic [YAW+XAW-1:0]    wr_addr;
  logic [YAW+XAW-1:0]    rd_addr [4];
  logic [3:0][PW-1:0]    rd_data;
  logic                  tp_r, bp_r, lp_r, rp_r;

  assign wr_en = in_acc && (in_tuser == OP_WRITE)
                 && ({1'b0, in_pos_x} < 13'(MAX_WIDTH))
                 && ({1'b0, in_pos_y} < 13'(MAX_HEIGHT));
  assign wr_bank = {in_pos_y[0], in_pos_x[0]};
  assign wr_addr = {YAW'(in_pos_y[YW-1:0] >> 1), XAW'(in_pos_x[XW-1:0] >> 1)};

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      logic [YW-1:0] row;
      logic [XW-1:0] col;
      row = (top[0] == b[1]) ? top : bot;
      col = (left[0] == b[0]) ? left : right;
      rd_addr[b] = {YAW'(row >> 1), XAW'(col >> 1)};
    end
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [PW-1:0] mem [BANK_DEPTH];
    logic [PW-1:0] rdata_r;

    always_ff @(posedge clk) begin
      if (wr_en && wr_bank == 2'(b)) begin
        mem[wr_addr] <= in_pix;
      end
      if (state_r == ST_CLAMP) begin
        rdata_r <= mem[rd_addr[b]];
      end
    end

    assign rd_data[b] = rdata_r;
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_CLAMP) begin
      tp_r <= top[0];
      bp_r <= bot[0];
      lp_r <= left[0];
      rp_r <= right[0];
    end
  end

  // Horizontal then vertical blend.
  logic [PW-1:0]         ul, ur, ll, lr;
  logic [3:0][CB-1:0]    up_r, lo_r, res_r;

  assign ul = rd_data[{tp_r, lp_r}];
  assign ur = rd_data[{tp_r, rp_r}];
  assign ll = rd_data[{bp_r, lp_r}];
  assign lr = rd_data[{bp_r, rp_r}];

  always_ff @(posedge clk) begin
    if (state_r == ST_LERPX) begin
      for (int c = 0; c < 4; c++) begin
        up_r[c] <= lerp(ul[c*CB +: CB], ur[c*CB +: CB], fx_r);
        lo_r[c] <= lerp(ll[c*CB +: CB], lr[c*CB +: CB], fx_r);
      end
    end
    if (load_out) begin
      for (int c = 0; c < 4; c++) begin
        res_r[c] <= lerp(up_r[c], lo_r[c], fy_r);
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {CHAN_FIELD_BITS'(res_r[3]), CHAN_FIELD_BITS'(res_r[2]),
                       CHAN_FIELD_BITS'(res_r[1]), CHAN_FIELD_BITS'(res_r[0])};

`ifndef ASSERT_OFF
  a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == OP_READ) |-> ##4 (state_r == ST_LERPY))
    else $error("read word did not reach the vertical blend in four cycles");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_LERPY))
    else $error("result appeared without a finished read");

  a_free_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LERPY && !out_valid_r) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("finished read not loaded into a free output register");
`endif

endmodule

`default_nettype wire
